FILE: rtl/core/hcts_pkg.sv
// Shared constants, types and helpers for the Hill cipher text stream block.
`default_nettype none

package hcts_pkg;

  localparam int HOLD_DEPTH_DEF   = 32;
  localparam int MATRIX_ORDER_DEF = 3;

  localparam int KEY_W     = 45;
  localparam int ENTRY_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int MODULUS   = 26;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_UPPER_X = 8'h58;
  localparam logic [7:0] CASE_BIT      = 8'h20;
  localparam logic [ENTRY_W-1:0] PAD_CODE = ENTRY_W'(ASCII_UPPER_X - ASCII_UPPER_A);

  localparam logic [KEY_W-1:0] FWD_KEY_RESET = 45'd20962312099377;
  localparam logic [KEY_W-1:0] INV_KEY_RESET = 45'd18717687135524;

  localparam logic [CFG_IDX_W-1:0] REG_FWD_KEY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_KEY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hcts_if.sv
// Valid/ready channel interfaces for text bytes in and transformed bytes out.
`default_nettype none

interface hcts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface hcts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       overflow;

  modport source (output valid, output out_byte, output last_of_run, output overflow,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input overflow,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hcts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hcts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hill_cipher_text_stream.sv
// Hill cipher text stream: holds bytes per letter group, emits the transformed run.
// A byte that completes a group or ends a message is taken in ST_IDLE; in ST_CALC the key
// matrix is applied one row per cycle into a registered row sum, then reduced mod 26; in
// ST_EMIT each held byte passes the hold RAM read and then the output load, one result
// per cycle while the output is ready. Input bytes are taken one per cycle, only in
// ST_IDLE; the flushed run is read out through the single RAM read port.
// Reset (rst_n, synchronous, active low): counts and flags cleared, keys to defaults,
// direction encrypt; hold RAM contents are not cleared.
`default_nettype none

module hill_cipher_text_stream #(
  parameter int HOLD_DEPTH   = hcts_pkg::HOLD_DEPTH_DEF,
  parameter int MATRIX_ORDER = hcts_pkg::MATRIX_ORDER_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hcts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hcts_pkg::KEY_W-1:0]     cfg_data,
  hcts_in_if.sink                             in_ch,
  hcts_out_if.source                          out_ch
);

  import hcts_pkg::*;

  localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
  localparam int AW    = $clog2(HOLD_DEPTH);
  localparam int LC_W  = $clog2(MATRIX_ORDER + 1);
  localparam int GI_W  = $clog2(MATRIX_ORDER);
  localparam int SUM_W = $clog2(MATRIX_ORDER * 31 * 25 + 1);
  localparam int RECIP = 2521;
  localparam int RSH   = 16;
  localparam int QP_W  = SUM_W + 12;

  localparam logic [CNT_W-1:0] HOLD_FULL = CNT_W'(HOLD_DEPTH);
  localparam logic [LC_W-1:0]  N_LC      = LC_W'(MATRIX_ORDER);

  state_t state_r, state_nxt;

  logic [KEY_W-1:0] fwd_key_r, inv_key_r;
  logic             dir_r;

  logic [CNT_W-1:0]   held_cnt_r;
  logic [LC_W-1:0]    let_cnt_r;
  logic               drop_r;
  logic [ENTRY_W-1:0] grp_r [MATRIX_ORDER];

  logic [CNT_W-1:0] emit_cnt_r;
  logic [LC_W-1:0]  present_r;
  logic             ovf_r;

  logic [LC_W-1:0]    calc_idx_r;
  logic [SUM_W-1:0]   sum_r;
  logic [GI_W-1:0]    sum_row_r;
  logic               sum_v_r;
  logic [ENTRY_W-1:0] res_r [MATRIX_ORDER];

  logic [CNT_W-1:0] rd_idx_r;
  logic             rd_pend_r;
  logic [LC_W-1:0]  li_r;
  logic [LC_W-1:0]  pad_idx_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_ovf_r;

  logic             acc, full, take_letter, group_done, flush, pad_sel;
  logic [CNT_W-1:0] held_new;
  logic [LC_W-1:0]  let_new;
  logic             drop_new;

  logic [KEY_W-1:0]   key_sel;
  logic [SUM_W-1:0]   row_sum;
  logic [QP_W-1:0]    qprod;
  logic [QP_W-1:0]    qval;
  logic [ENTRY_W-1:0] rem;

  logic       slot_free, issue, load_held, held_done, pad_left, load_pad;
  logic [7:0] ram_q, base, held_out;
  logic       held_letter, held_last;

  // Input side
  assign acc         = in_ch.valid && in_ch.ready;
  assign full        = (held_cnt_r == HOLD_FULL);
  assign take_letter = !full && is_letter(in_ch.in_byte) && (let_cnt_r != N_LC);
  assign held_new    = full ? held_cnt_r : CNT_W'(held_cnt_r + 1'b1);
  assign let_new     = take_letter ? LC_W'(let_cnt_r + 1'b1) : let_cnt_r;
  assign drop_new    = drop_r | full;
  assign group_done  = (let_new == N_LC);
  assign flush       = acc && (group_done || (in_ch.end_of_message && held_new != '0));
  assign pad_sel     = !group_done && !dir_r && (let_new != '0);

  // Matrix row and mod 26
  assign key_sel = dir_r ? inv_key_r : fwd_key_r;

  always_comb begin
    logic [ENTRY_W-1:0] ent;
    logic [ENTRY_W-1:0] g;
    logic [9:0]         prod;
    int                 idx;
    row_sum = '0;
    for (int c = 0; c < MATRIX_ORDER; c++) begin
      idx  = int'(calc_idx_r) * MATRIX_ORDER + c;
      ent  = ENTRY_W'(key_sel >> (ENTRY_W * idx));
      g    = (LC_W'(c) < present_r) ? grp_r[c] : PAD_CODE;
      prod = 10'(ent) * 10'(g);
      row_sum = SUM_W'(row_sum + SUM_W'(prod));
    end
  end

  assign qprod = QP_W'(sum_r) * QP_W'(RECIP);
  assign qval  = qprod >> RSH;
  assign rem   = ENTRY_W'(sum_r - SUM_W'(qval * QP_W'(MODULUS)));

  // Output side
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign issue       = (state_r == ST_EMIT) && (rd_idx_r != emit_cnt_r) &&
                       (!rd_pend_r || slot_free);
  assign load_held   = (state_r == ST_EMIT) && rd_pend_r && slot_free;
  assign held_done   = (rd_idx_r == emit_cnt_r) && !rd_pend_r;
  assign pad_left    = (pad_idx_r != N_LC);
  assign load_pad    = (state_r == ST_EMIT) && held_done && pad_left && slot_free;
  assign base        = dir_r ? ASCII_LOWER_A : ASCII_UPPER_A;
  assign held_letter = is_letter(ram_q) && (li_r != N_LC);
  assign held_out    = held_letter ? 8'(base + 8'(res_r[li_r[GI_W-1:0]])) : ram_q;
  assign held_last   = (rd_idx_r == emit_cnt_r) && !pad_left;

  hcts_ram #(
    .WIDTH(8),
    .DEPTH(HOLD_DEPTH)
  ) u_hold_ram (
    .clk  (clk),
    .we   (acc && !full),
    .waddr(held_cnt_r[AW-1:0]),
    .wdata(in_ch.in_byte),
    .re   (issue),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(ram_q)
  );

  // State machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (flush) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (calc_idx_r == N_LC) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (held_done && !pad_left) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_key_r <= FWD_KEY_RESET;
      inv_key_r <= INV_KEY_RESET;
      dir_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FWD_KEY:   fwd_key_r <= cfg_data;
        REG_INV_KEY:   inv_key_r <= cfg_data;
        REG_DIRECTION: dir_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold bookkeeping and flush snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
      let_cnt_r  <= '0;
      drop_r     <= 1'b0;
      emit_cnt_r <= '0;
      present_r  <= '0;
      ovf_r      <= 1'b0;
      pad_idx_r  <= N_LC;
      li_r       <= '0;
    end else if (acc) begin
      if (flush) begin
        held_cnt_r <= '0;
        let_cnt_r  <= '0;
        drop_r     <= 1'b0;
        emit_cnt_r <= held_new;
        present_r  <= let_new;
        ovf_r      <= drop_new;
        pad_idx_r  <= pad_sel ? let_new : N_LC;
        li_r       <= '0;
      end else begin
        held_cnt_r <= held_new;
        let_cnt_r  <= let_new;
        drop_r     <= drop_new;
      end
    end else begin
      if (load_held && held_letter) begin
        li_r <= LC_W'(li_r + 1'b1);
      end
      if (load_pad) begin
        pad_idx_r <= LC_W'(pad_idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_letter && acc) begin
      grp_r[let_cnt_r[GI_W-1:0]] <= ENTRY_W'((in_ch.in_byte | CASE_BIT) - ASCII_LOWER_A);
    end
  end

  // Row sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_idx_r <= '0;
      sum_v_r    <= 1'b0;
    end else begin
      if (state_r == ST_CALC && calc_idx_r != N_LC) begin
        calc_idx_r <= LC_W'(calc_idx_r + 1'b1);
        sum_v_r    <= 1'b1;
      end else begin
        calc_idx_r <= (state_r == ST_CALC) ? calc_idx_r : '0;
        sum_v_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= row_sum;
    sum_row_r <= calc_idx_r[GI_W-1:0];
    if (sum_v_r) begin
      res_r[sum_row_r] <= rem;
    end
  end

  // Hold RAM read pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      rd_pend_r <= 1'b0;
    end else if (state_r != ST_EMIT) begin
      rd_idx_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      if (issue) begin
        rd_idx_r <= CNT_W'(rd_idx_r + 1'b1);
      end
      rd_pend_r <= issue ? 1'b1 : (rd_pend_r && !slot_free);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_held || load_pad) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_held) begin
      out_byte_r <= held_out;
      out_last_r <= held_last;
      out_ovf_r  <= ovf_r;
    end else if (load_pad) begin
      out_byte_r <= 8'(base + 8'(res_r[pad_idx_r[GI_W-1:0]]));
      out_last_r <= (pad_idx_r == LC_W'(MATRIX_ORDER - 1));
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.overflow    = out_ovf_r;

endmodule

`default_nettype wire
